### rtl/core/fpru_pkg.sv
package fpru_pkg;

    // Size of the coefficient table; the register map fills only five of its entries.
    localparam int MAX_COEFFS = 8;

    // Register indexes on the configuration port (byte address 8 * index).
    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_AFFINE_C = 3'd2;
    localparam logic [2:0] REG_AFFINE_D = 3'd3;
    localparam logic [2:0] REG_AFFINE_E = 3'd4;
    localparam logic [2:0] REG_POLY_LO  = 3'd5;
    localparam logic [2:0] REG_POLY_MID = 3'd6;
    localparam logic [2:0] REG_POLY_TOP = 3'd7;

    // Affine element c resets to 1.0 in Q2.30.
    localparam logic signed [31:0] AFFINE_C_RESET = 32'sh4000_0000;

    // Undistorted plane point with its squared radius.
    typedef struct packed {
        logic               det_zero;
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic [63:0]        sq_sum;
    } fpru_plane_t;

    // Full ray before normalization.
    typedef struct packed {
        logic               det_zero;
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic signed [31:0] mz;
    } fpru_ray_t;

endpackage

### rtl/core/fpru_div.sv
// Pipelined restoring divider: one quotient bit per stage, unsigned operands.
// The numerator bits above the quotient width must be below the divisor.
module fpru_div #(
    parameter int NW = 50,
    parameter int DW = 35,
    parameter int QW = 50,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quot,
    output logic [SW-1:0] side_out
);

    logic          valid_reg [0:QW];
    logic [DW-1:0] rem_reg   [0:QW];
    logic [QW-1:0] lo_reg    [0:QW];
    logic [DW-1:0] den_reg   [0:QW];
    logic [QW-1:0] q_reg     [0:QW];
    logic [SW-1:0] side_reg  [0:QW];

    // Entry stage registers the operands.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= DW'(num >> QW);
        lo_reg[0]   <= num[QW-1:0];
        den_reg[0]  <= den;
        q_reg[0]    <= '0;
        side_reg[0] <= side_in;
    end

    // Each stage shifts in one numerator bit and tries one subtraction.
    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [DW:0]   sh;
        logic [DW:0]   diff;
        logic          take;
        logic [DW-1:0] rem_next;

        assign sh       = {rem_reg[k], lo_reg[k][QW-1]};
        assign diff     = sh - {1'b0, den_reg[k]};
        assign take     = (sh >= {1'b0, den_reg[k]});
        assign rem_next = take ? diff[DW-1:0] : sh[DW-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= rem_next;
            lo_reg[k+1]   <= {lo_reg[k][QW-2:0], 1'b0};
            den_reg[k+1]  <= den_reg[k];
            q_reg[k+1]    <= {q_reg[k][QW-2:0], take};
            side_reg[k+1] <= side_reg[k];
        end
    end

    assign out_valid = valid_reg[QW];
    assign quot      = q_reg[QW];
    assign side_out  = side_reg[QW];

endmodule

### rtl/core/fpru_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module fpru_isqrt #(
    parameter int NW = 64,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [NW-1:0]   radicand,
    input  logic [SW-1:0]   side_in,
    output logic            out_valid,
    output logic [NW/2-1:0] root,
    output logic [SW-1:0]   side_out
);

    localparam int ST = NW / 2;

    logic          valid_reg [0:ST];
    logic [NW-1:0] x_reg     [0:ST];
    logic [NW-1:0] res_reg   [0:ST];
    logic [SW-1:0] side_reg  [0:ST];

    // Entry stage registers the radicand.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= radicand;
        res_reg[0]  <= '0;
        side_reg[0] <= side_in;
    end

    // Digit-by-digit root: each stage settles one bit of the result.
    for (genvar k = 0; k < ST; k++)
    begin : g_stage
        localparam logic [NW-1:0] BIT = NW'(1) << (NW - 2 - 2 * k);
        logic [NW-1:0] trial;
        logic          take;

        assign trial = res_reg[k] + BIT;
        assign take  = (x_reg[k] >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[k+1]    <= take ? (x_reg[k] - trial) : x_reg[k];
            res_reg[k+1]  <= take ? ((res_reg[k] >> 1) + BIT) : (res_reg[k] >> 1);
            side_reg[k+1] <= side_reg[k];
        end
    end

    assign out_valid = valid_reg[ST];
    assign root      = res_reg[ST][ST-1:0];
    assign side_out  = side_reg[ST];

endmodule

### rtl/core/fisheye_pixel_to_ray_unprojection_unit.sv
// Fisheye pixel to unit ray unprojection.
// Input: pulse start with pixel_u / pixel_v (unsigned Q12.4). busy is always
// low, so one pixel transfer is taken on every clock edge where start is high.
// Output: done is high for exactly one cycle with ray_x / ray_y / ray_z
// (signed Q1.15) and invalid; the receiver must take it in that cycle.
// The path includes the two 50-stage offset dividers, the two 32-stage square
// roots, the Horner chain (a multiply and an add stage per coefficient below
// the leading one) and the 16-stage normalizing dividers. Throughput is one
// pixel per clock. Results leave in the order the pixels arrived.
// Reset clears all pipeline valid bits and restores the register defaults
// (identity affine matrix, zero centre and coefficients).
// The user must write the APB port (8-byte register spacing, pready tied high)
// only while no pixel is in flight; the block itself does not enforce this.
module fisheye_pixel_to_ray_unprojection_unit #(
    parameter int COEFF_COUNT = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        pixel_u,
    input  logic [15:0]        pixel_v,
    output logic               done,
    output logic signed [15:0] ray_x,
    output logic signed [15:0] ray_y,
    output logic signed [15:0] ray_z,
    output logic               invalid,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    localparam int DIV_NW  = 50;
    localparam int DIV_DW  = 35;
    localparam int SQ_W    = 64;
    localparam int Q15_NW  = 47;
    localparam int Q15_DW  = 32;
    localparam int Q15_QW  = 16;
    localparam int STEPS   = COEFF_COUNT - 1;
    localparam int LATENCY = 3 + (DIV_NW + 1) + 2 + (SQ_W / 2 + 1) + 2 * STEPS + 1
                             + (SQ_W / 2 + 1) + (Q15_QW + 1) + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0]        center_x_reg;
    logic [15:0]        center_y_reg;
    logic signed [31:0] affine_c_reg;
    logic signed [31:0] affine_d_reg;
    logic signed [31:0] affine_e_reg;
    logic [63:0]        poly_lo_reg;
    logic [63:0]        poly_mid_reg;
    logic signed [31:0] poly_top_reg;

    assign pready = 1'b1;
    assign busy   = 1'b0;

    // A write transfer completes in the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            affine_c_reg <= fpru_pkg::AFFINE_C_RESET;
            affine_d_reg <= '0;
            affine_e_reg <= '0;
            poly_lo_reg  <= '0;
            poly_mid_reg <= '0;
            poly_top_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[5:3])
                fpru_pkg::REG_CENTER_X: center_x_reg <= pwdata[15:0];
                fpru_pkg::REG_CENTER_Y: center_y_reg <= pwdata[15:0];
                fpru_pkg::REG_AFFINE_C: affine_c_reg <= pwdata[31:0];
                fpru_pkg::REG_AFFINE_D: affine_d_reg <= pwdata[31:0];
                fpru_pkg::REG_AFFINE_E: affine_e_reg <= pwdata[31:0];
                fpru_pkg::REG_POLY_LO:  poly_lo_reg  <= pwdata;
                fpru_pkg::REG_POLY_MID: poly_mid_reg <= pwdata;
                fpru_pkg::REG_POLY_TOP: poly_top_reg <= pwdata[31:0];
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        unique case (paddr[5:3])
            fpru_pkg::REG_CENTER_X: prdata = {48'd0, center_x_reg};
            fpru_pkg::REG_CENTER_Y: prdata = {48'd0, center_y_reg};
            fpru_pkg::REG_AFFINE_C: prdata = {32'd0, affine_c_reg};
            fpru_pkg::REG_AFFINE_D: prdata = {32'd0, affine_d_reg};
            fpru_pkg::REG_AFFINE_E: prdata = {32'd0, affine_e_reg};
            fpru_pkg::REG_POLY_LO:  prdata = poly_lo_reg;
            fpru_pkg::REG_POLY_MID: prdata = poly_mid_reg;
            fpru_pkg::REG_POLY_TOP: prdata = {32'd0, poly_top_reg};
        endcase
    end

    // Coefficient table; entries above a4 read as zero.
    logic signed [31:0] coef [0:fpru_pkg::MAX_COEFFS-1];

    always_comb
    begin
        for (int i = 0; i < fpru_pkg::MAX_COEFFS; i++)
        begin
            coef[i] = '0;
        end
        coef[0] = poly_lo_reg[31:0];
        coef[1] = poly_lo_reg[63:32];
        coef[2] = poly_mid_reg[31:0];
        coef[3] = poly_mid_reg[63:32];
        coef[4] = poly_top_reg;
    end

    // ------------------------------------------------------------------
    // Helper functions
    // ------------------------------------------------------------------

    // Signed quotient from magnitude and sign, clamped to 32 bits.
    function automatic logic signed [31:0] sat_quot(logic [DIV_NW-1:0] q, logic neg);
        logic signed [32:0] t;
        logic signed [31:0] r;
        t = -$signed({1'b0, q[31:0]});
        if (!neg)
        begin
            r = (q > DIV_NW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : q[31:0];
        end
        else
        begin
            r = (q > DIV_NW'(33'h0_8000_0000)) ? 32'sh8000_0000 : t[31:0];
        end
        return r;
    endfunction

    // One Horner step: floor(prod / 2^16) + coefficient, clamped to 32 bits.
    function automatic logic signed [31:0] horner_add(logic signed [64:0] prod,
                                                      logic signed [31:0] c);
        logic signed [49:0] t;
        logic signed [31:0] r;
        t = 50'(prod >>> 16) + 50'(c);
        if (t > 50'sh0_7FFF_FFFF)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (t < -50'sh0_8000_0000)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = t[31:0];
        end
        return r;
    endfunction

    // Magnitude of a 33-bit signed component (fits in 32 bits here).
    function automatic logic [31:0] mag33(logic signed [32:0] m);
        logic signed [32:0] t;
        t = m[32] ? -m : m;
        return t[31:0];
    endfunction

    // Final Q1.15 component: clamp the magnitude, apply sign, zero if invalid.
    function automatic logic signed [15:0] ray_out(logic [Q15_QW-1:0] q, logic neg,
                                                   logic inv);
        logic [14:0]        m;
        logic signed [15:0] r;
        m = (q > Q15_QW'(16'd32767)) ? 15'h7FFF : q[14:0];
        r = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
        return inv ? 16'sd0 : r;
    endfunction

    // ------------------------------------------------------------------
    // Stage A: offsets from the image centre
    // ------------------------------------------------------------------
    logic               a_valid_reg;
    logic signed [16:0] du_reg;
    logic signed [16:0] dv_reg;
    logic signed [16:0] du_next;
    logic signed [16:0] dv_next;

    assign du_next = $signed({1'b0, pixel_u}) - $signed({1'b0, center_x_reg});
    assign dv_next = $signed({1'b0, pixel_v}) - $signed({1'b0, center_y_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        du_reg <= du_next;
        dv_reg <= dv_next;
    end

    // ------------------------------------------------------------------
    // Stage B: products of the affine terms
    // ------------------------------------------------------------------
    logic               b_valid_reg;
    logic signed [63:0] de_reg;
    logic signed [48:0] ddv_reg;
    logic signed [48:0] cdv_reg;
    logic signed [48:0] edu_reg;
    logic signed [16:0] b_du_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        de_reg   <= affine_d_reg * affine_e_reg;
        ddv_reg  <= affine_d_reg * dv_reg;
        cdv_reg  <= affine_c_reg * dv_reg;
        edu_reg  <= affine_e_reg * du_reg;
        b_du_reg <= du_reg;
    end

    // ------------------------------------------------------------------
    // Stage C: determinant and numerators of the inverse
    // ------------------------------------------------------------------
    logic               c_valid_reg;
    logic signed [34:0] det_reg;
    logic signed [49:0] nx_reg;
    logic signed [49:0] ny_reg;
    logic signed [34:0] det_next;
    logic signed [49:0] nx_next;
    logic signed [49:0] ny_next;

    assign det_next = 35'(affine_c_reg) - 35'(de_reg >>> 30);
    assign nx_next  = (50'(b_du_reg) <<< 30) - 50'(ddv_reg);
    assign ny_next  = 50'(cdv_reg) - 50'(edu_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        det_reg <= det_next;
        nx_reg  <= nx_next;
        ny_reg  <= ny_next;
    end

    // Magnitudes and signs for the offset dividers; a zero determinant
    // divides by one and is flagged.
    logic               det_zero;
    logic [DIV_DW-1:0]  det_mag;
    logic [DIV_DW-1:0]  div_den;
    logic signed [49:0] nx_abs;
    logic signed [49:0] ny_abs;
    logic               neg_x;
    logic               neg_y;

    assign det_zero = (det_reg == '0);
    assign det_mag  = det_reg[34] ? 35'(-det_reg) : 35'(det_reg);
    assign div_den  = det_zero ? DIV_DW'(1) : det_mag;
    assign nx_abs   = nx_reg[49] ? -nx_reg : nx_reg;
    assign ny_abs   = ny_reg[49] ? -ny_reg : ny_reg;
    assign neg_x    = nx_reg[49] ^ det_reg[34];
    assign neg_y    = ny_reg[49] ^ det_reg[34];

    logic              dx_valid;
    logic              dy_valid;
    logic [DIV_NW-1:0] qx_mag;
    logic [DIV_NW-1:0] qy_mag;
    logic [1:0]        dx_side;
    logic              dy_side;

    fpru_div #(
        .NW (DIV_NW),
        .DW (DIV_DW),
        .QW (DIV_NW),
        .SW (2)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid_reg),
        .num       (nx_abs),
        .den       (div_den),
        .side_in   ({neg_x, det_zero}),
        .out_valid (dx_valid),
        .quot      (qx_mag),
        .side_out  (dx_side)
    );

    fpru_div #(
        .NW (DIV_NW),
        .DW (DIV_DW),
        .QW (DIV_NW),
        .SW (1)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid_reg),
        .num       (ny_abs),
        .den       (div_den),
        .side_in   (neg_y),
        .out_valid (dy_valid),
        .quot      (qy_mag),
        .side_out  (dy_side)
    );

    // ------------------------------------------------------------------
    // Stage E: signed, clamped plane coordinates
    // ------------------------------------------------------------------
    logic               e_valid_reg;
    logic signed [31:0] mx_reg;
    logic signed [31:0] my_reg;
    logic               e_det_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else
        begin
            e_valid_reg <= dx_valid && dy_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg         <= sat_quot(qx_mag, dx_side[1]);
        my_reg         <= sat_quot(qy_mag, dy_side);
        e_det_zero_reg <= dx_side[0];
    end

    // ------------------------------------------------------------------
    // Stage F: squares of the plane coordinates
    // ------------------------------------------------------------------
    logic               f_valid_reg;
    logic [63:0]        sqx_reg;
    logic [63:0]        sqy_reg;
    logic signed [31:0] f_mx_reg;
    logic signed [31:0] f_my_reg;
    logic               f_det_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sqx_reg        <= mx_reg * mx_reg;
        sqy_reg        <= my_reg * my_reg;
        f_mx_reg       <= mx_reg;
        f_my_reg       <= my_reg;
        f_det_zero_reg <= e_det_zero_reg;
    end

    // Radius root; the squared sum rides along for the norm.
    fpru_pkg::fpru_plane_t plane_in;
    fpru_pkg::fpru_plane_t plane_out;
    logic [$bits(fpru_pkg::fpru_plane_t)-1:0] plane_side_out;
    logic                                     r_valid;
    logic [SQ_W/2-1:0]                        r_root;

    always_comb
    begin
        plane_in.det_zero = f_det_zero_reg;
        plane_in.mx       = f_mx_reg;
        plane_in.my       = f_my_reg;
        plane_in.sq_sum   = sqx_reg + sqy_reg;
    end

    fpru_isqrt #(
        .NW (SQ_W),
        .SW ($bits(fpru_pkg::fpru_plane_t))
    ) u_sqrt_r (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid_reg),
        .radicand  (plane_in.sq_sum),
        .side_in   (plane_in),
        .out_valid (r_valid),
        .root      (r_root),
        .side_out  (plane_side_out)
    );

    assign plane_out = plane_side_out;

    // ------------------------------------------------------------------
    // Horner chain: a multiply stage and an add stage per lower-order coefficient
    // ------------------------------------------------------------------
    logic                  hm_valid_reg [0:STEPS-1];
    logic signed [64:0]    hm_prod_reg  [0:STEPS-1];
    logic [31:0]           hm_r_reg     [0:STEPS-1];
    fpru_pkg::fpru_plane_t hm_side_reg  [0:STEPS-1];
    logic                  ha_valid_reg [0:STEPS-1];
    logic signed [31:0]    ha_acc_reg   [0:STEPS-1];
    logic [31:0]           ha_r_reg     [0:STEPS-1];
    fpru_pkg::fpru_plane_t ha_side_reg  [0:STEPS-1];

    for (genvar s = 0; s < STEPS; s++)
    begin : g_horner
        logic                  v_in;
        logic signed [31:0]    acc_in;
        logic [31:0]           r_in;
        fpru_pkg::fpru_plane_t side_in;

        if (s == 0)
        begin : g_first
            assign v_in    = r_valid;
            assign acc_in  = coef[COEFF_COUNT-1];
            assign r_in    = r_root;
            assign side_in = plane_out;
        end
        else
        begin : g_next
            assign v_in    = ha_valid_reg[s-1];
            assign acc_in  = ha_acc_reg[s-1];
            assign r_in    = ha_r_reg[s-1];
            assign side_in = ha_side_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                hm_valid_reg[s] <= 1'b0;
                ha_valid_reg[s] <= 1'b0;
            end
            else
            begin
                hm_valid_reg[s] <= v_in;
                ha_valid_reg[s] <= hm_valid_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            hm_prod_reg[s] <= acc_in * $signed({1'b0, r_in});
            hm_r_reg[s]    <= r_in;
            hm_side_reg[s] <= side_in;
            ha_acc_reg[s]  <= horner_add(hm_prod_reg[s], coef[COEFF_COUNT-2-s]);
            ha_r_reg[s]    <= hm_r_reg[s];
            ha_side_reg[s] <= hm_side_reg[s];
        end
    end

    // ------------------------------------------------------------------
    // Stage H: square of the axial component
    // ------------------------------------------------------------------
    logic                  h_valid_reg;
    logic [63:0]           mz2_reg;
    logic signed [31:0]    mz_reg;
    fpru_pkg::fpru_plane_t h_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_valid_reg <= 1'b0;
        end
        else
        begin
            h_valid_reg <= ha_valid_reg[STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        mz2_reg    <= ha_acc_reg[STEPS-1] * ha_acc_reg[STEPS-1];
        mz_reg     <= ha_acc_reg[STEPS-1];
        h_side_reg <= ha_side_reg[STEPS-1];
    end

    // Norm root over all three components.
    fpru_pkg::fpru_ray_t                    ray_in;
    fpru_pkg::fpru_ray_t                    ray_mid;
    logic [$bits(fpru_pkg::fpru_ray_t)-1:0] ray_side_out;
    logic                                   n_valid;
    logic [SQ_W/2-1:0]                      norm;
    logic [SQ_W-1:0]                        norm_sq;

    always_comb
    begin
        ray_in.det_zero = h_side_reg.det_zero;
        ray_in.mx       = h_side_reg.mx;
        ray_in.my       = h_side_reg.my;
        ray_in.mz       = mz_reg;
    end

    assign norm_sq = h_side_reg.sq_sum + mz2_reg;

    fpru_isqrt #(
        .NW (SQ_W),
        .SW ($bits(fpru_pkg::fpru_ray_t))
    ) u_sqrt_n (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (h_valid_reg),
        .radicand  (norm_sq),
        .side_in   (ray_in),
        .out_valid (n_valid),
        .root      (norm),
        .side_out  (ray_side_out)
    );

    assign ray_mid = ray_side_out;

    // ------------------------------------------------------------------
    // Normalization to Q1.15 with rounding
    // ------------------------------------------------------------------
    logic                 norm_zero;
    logic                 bad;
    logic [Q15_DW-1:0]    q_den;
    logic signed [32:0]   cx;
    logic signed [32:0]   cy;
    logic signed [32:0]   cz;
    logic [Q15_NW-1:0]    num_x;
    logic [Q15_NW-1:0]    num_y;
    logic [Q15_NW-1:0]    num_z;

    assign norm_zero = (norm == '0);
    assign bad       = norm_zero || ray_mid.det_zero;
    assign q_den     = norm_zero ? Q15_DW'(1) : norm;
    assign cx        = 33'(ray_mid.mx);
    assign cy        = 33'(ray_mid.my);
    assign cz        = -33'(ray_mid.mz);
    assign num_x     = {mag33(cx), 15'd0} + Q15_NW'(norm >> 1);
    assign num_y     = {mag33(cy), 15'd0} + Q15_NW'(norm >> 1);
    assign num_z     = {mag33(cz), 15'd0} + Q15_NW'(norm >> 1);

    logic              ox_valid;
    logic              oy_valid;
    logic              oz_valid;
    logic [Q15_QW-1:0] ox_q;
    logic [Q15_QW-1:0] oy_q;
    logic [Q15_QW-1:0] oz_q;
    logic [1:0]        ox_side;
    logic              oy_side;
    logic              oz_side;

    fpru_div #(
        .NW (Q15_NW),
        .DW (Q15_DW),
        .QW (Q15_QW),
        .SW (2)
    ) u_q15_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (n_valid),
        .num       (num_x),
        .den       (q_den),
        .side_in   ({cx[32], bad}),
        .out_valid (ox_valid),
        .quot      (ox_q),
        .side_out  (ox_side)
    );

    fpru_div #(
        .NW (Q15_NW),
        .DW (Q15_DW),
        .QW (Q15_QW),
        .SW (1)
    ) u_q15_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (n_valid),
        .num       (num_y),
        .den       (q_den),
        .side_in   (cy[32]),
        .out_valid (oy_valid),
        .quot      (oy_q),
        .side_out  (oy_side)
    );

    fpru_div #(
        .NW (Q15_NW),
        .DW (Q15_DW),
        .QW (Q15_QW),
        .SW (1)
    ) u_q15_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (n_valid),
        .num       (num_z),
        .den       (q_den),
        .side_in   (cz[32]),
        .out_valid (oz_valid),
        .quot      (oz_q),
        .side_out  (oz_side)
    );

    // ------------------------------------------------------------------
    // Output register: one-cycle result transfer
    // ------------------------------------------------------------------
    logic               done_reg;
    logic signed [15:0] ray_x_reg;
    logic signed [15:0] ray_y_reg;
    logic signed [15:0] ray_z_reg;
    logic               invalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ox_valid && oy_valid && oz_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ray_x_reg   <= ray_out(ox_q, ox_side[1], ox_side[0]);
        ray_y_reg   <= ray_out(oy_q, oy_side, ox_side[0]);
        ray_z_reg   <= ray_out(oz_q, oz_side, ox_side[0]);
        invalid_reg <= ox_side[0];
    end

    assign done    = done_reg;
    assign ray_x   = ray_x_reg;
    assign ray_y   = ray_y_reg;
    assign ray_z   = ray_z_reg;
    assign invalid = invalid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Every accepted pixel produces a result after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("result missing after pipeline latency");

    // No result without a pixel accepted the same latency earlier.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching pixel");

    // An invalid result carries a zero ray.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && invalid |-> (ray_x == 16'sd0 && ray_y == 16'sd0 && ray_z == 16'sd0))
        else $error("invalid result with nonzero ray");

    // A valid unit ray always has a nonzero component and never the most
    // negative code.
    a_valid_ray: assert property (@(posedge clk) disable iff (!rst_n)
        done && !invalid |-> ((ray_x != 16'sd0 || ray_y != 16'sd0 || ray_z != 16'sd0)
                              && ray_x != 16'sh8000 && ray_y != 16'sh8000
                              && ray_z != 16'sh8000))
        else $error("valid result is not a plausible unit ray");

endmodule
